### rtl/sample_percentile_engine_top_defines.svh
// Assertion macros for the sample percentile engine checker.
// Used by the checker file only; no other dependencies.
`ifndef SAMPLE_PERCENTILE_ENGINE_TOP_DEFINES_SVH
`define SAMPLE_PERCENTILE_ENGINE_TOP_DEFINES_SVH

// Clocked implication, skipped while reset is high
`define PSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, but also checked during reset
`define PSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pse_pkg.sv
// Shared types and constants of the sample percentile engine.
// No dependencies.
`default_nettype none
package pse_pkg;

  localparam int MAX_SAMPLES_DEF = 256;
  localparam int FRAC_W          = 17;
  localparam int DATA_W          = 32;
  localparam int TOTAL_W         = 9;
  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
  localparam logic [FRAC_W-1:0] FRAC_RST  = 17'd32768;
  localparam logic [15:0]       TOLERANCE = 16'd655;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_FIN,
    S_POS,
    S_SEL,
    S_LO,
    S_HI,
    S_MUL,
    S_ADD,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

### rtl/sample_percentile_engine_top.sv
// Flow: an item without a sample goes straight to the finish state; a sample is inserted into
// the sorted store through its single read port, each larger stored sample being read and
// shifted up one place before the new one is written. An item marked last then gives zero for
// an empty set, else does the position multiply, select and a store read, and unless the pick
// is direct, a second store read, difference multiply and add, before the result is valid.
// Throughput: one item at a time; input stall stays high until the item and its result are done.
// Reset (synchronous): empty set, overflow cleared, percentile fraction 32768.
`default_nettype none
module sample_percentile_engine_top #(
  parameter int MAX_SAMPLES = pse_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [pse_pkg::FRAC_W-1:0]         cfg_wr_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [pse_pkg::DATA_W-1:0]  sample_value,
  input  wire logic                               sample_present,
  input  wire logic                               last_item,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [pse_pkg::DATA_W-1:0]       percentile_value,
  output logic [pse_pkg::TOTAL_W-1:0]             sample_total,
  output logic                                    overflowed
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int POS_W = AW + pse_pkg::FRAC_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

  pse_pkg::state_t state, state_next;

  logic [pse_pkg::FRAC_W-1:0]        frac;
  logic [CW-1:0]                     cnt;
  logic                              ovf;
  logic signed [pse_pkg::DATA_W-1:0] val;
  logic                              last;
  logic [AW-1:0]                     j;
  logic [POS_W-1:0]                  pos;
  logic                              direct;
  logic signed [pse_pkg::DATA_W-1:0] lo;
  logic [pse_pkg::DATA_W-1:0]        diff;
  logic [pse_pkg::DATA_W+15:0]       prod;

  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic signed [pse_pkg::DATA_W-1:0] wr_data;
  logic [AW-1:0]                     rd_addr;
  logic signed [pse_pkg::DATA_W-1:0] rd_data;

  logic                              accept;
  logic                              shift;
  logic [pse_pkg::FRAC_W-1:0]        frac_sat;
  logic [AW-1:0]                     cnt_m1;
  logic [AW-1:0]                     idx;
  logic [POS_W-1:0]                  top;
  logic [POS_W-1:0]                  top_gap;
  logic                              near_lo;
  logic                              near_hi;
  logic                              idx_end;

  pse_store #(.MAX_SAMPLES(MAX_SAMPLES)) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign accept   = in_valid && !in_stall;
  assign shift    = (rd_data > val);
  assign frac_sat = (frac > pse_pkg::FRAC_ONE) ? pse_pkg::FRAC_ONE : frac;
  assign cnt_m1   = AW'(cnt - CW'(1));
  assign idx      = pos[AW+15:16];
  assign top      = POS_W'({cnt_m1, 16'd0});
  assign top_gap  = top - pos;
  assign near_lo  = (pos < POS_W'(pse_pkg::TOLERANCE));
  assign near_hi  = (top_gap < POS_W'(pse_pkg::TOLERANCE));
  assign idx_end  = ((CW'(idx) + CW'(1)) >= cnt);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pse_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (sample_present && cnt < CNT_MAX) ? pse_pkg::S_INS_RD : pse_pkg::S_FIN;
        end
      end
      pse_pkg::S_INS_RD:  state_next = (j == '0) ? pse_pkg::S_FIN : pse_pkg::S_INS_CMP;
      pse_pkg::S_INS_CMP: state_next = shift ? pse_pkg::S_INS_RD : pse_pkg::S_FIN;
      pse_pkg::S_FIN:     state_next = last ? pse_pkg::S_POS : pse_pkg::S_IDLE;
      pse_pkg::S_POS:     state_next = (cnt == '0) ? pse_pkg::S_OUT : pse_pkg::S_SEL;
      pse_pkg::S_SEL:     state_next = pse_pkg::S_LO;
      pse_pkg::S_LO:      state_next = direct ? pse_pkg::S_OUT : pse_pkg::S_HI;
      pse_pkg::S_HI:      state_next = pse_pkg::S_MUL;
      pse_pkg::S_MUL:     state_next = pse_pkg::S_ADD;
      pse_pkg::S_ADD:     state_next = pse_pkg::S_OUT;
      pse_pkg::S_OUT:     state_next = out_stall ? pse_pkg::S_OUT : pse_pkg::S_IDLE;
      default:            state_next = pse_pkg::S_IDLE;
    endcase
  end

  // Outputs and store port control
  always_comb begin
    in_stall  = rst || (state != pse_pkg::S_IDLE);
    out_valid = (state == pse_pkg::S_OUT);
    wr_en     = 1'b0;
    wr_addr   = j;
    wr_data   = val;
    rd_addr   = AW'(j - AW'(1));
    case (state)
      pse_pkg::S_INS_RD: begin
        wr_en = (j == '0);
      end
      pse_pkg::S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_data = shift ? rd_data : val;
      end
      pse_pkg::S_SEL: begin
        if (near_lo) begin
          rd_addr = '0;
        end else if (near_hi || idx_end) begin
          rd_addr = cnt_m1;
        end else begin
          rd_addr = idx;
        end
      end
      pse_pkg::S_LO: begin
        rd_addr = AW'(idx + AW'(1));
      end
      default: begin
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pse_pkg::S_IDLE;
      frac  <= pse_pkg::FRAC_RST;
      cnt   <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        frac <= cfg_wr_data;
      end
      // Count or flag the sample of an accepted item
      if (accept && sample_present) begin
        if (cnt < CNT_MAX) begin
          cnt <= cnt + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      // Drop the set once the result is taken
      if (state == pse_pkg::S_OUT && !out_stall) begin
        cnt <= '0;
        ovf <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      pse_pkg::S_IDLE: begin
        val  <= sample_value;
        last <= last_item;
        j    <= AW'(cnt);
      end
      pse_pkg::S_INS_CMP: begin
        if (shift) begin
          j <= AW'(j - AW'(1));
        end
      end
      pse_pkg::S_POS: begin
        pos              <= POS_W'(cnt_m1) * POS_W'(frac_sat);
        percentile_value <= '0;
        sample_total     <= pse_pkg::TOTAL_W'(cnt);
        overflowed       <= ovf;
      end
      pse_pkg::S_SEL: begin
        direct <= near_lo || near_hi || idx_end;
      end
      pse_pkg::S_LO: begin
        lo               <= rd_data;
        percentile_value <= rd_data;
      end
      pse_pkg::S_HI: begin
        diff <= pse_pkg::DATA_W'(rd_data - lo);
      end
      pse_pkg::S_MUL: begin
        prod <= diff * pos[15:0];
      end
      pse_pkg::S_ADD: begin
        percentile_value <= lo + $signed(prod[pse_pkg::DATA_W+15:16]);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/pse_store.sv
// Sample store: one write port, one read port with registered read data.
// Depends on pse_pkg for the data width and the default depth.
`default_nettype none
module pse_store #(
  parameter int MAX_SAMPLES = pse_pkg::MAX_SAMPLES_DEF,
  localparam int AW = $clog2(MAX_SAMPLES)
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic signed [pse_pkg::DATA_W-1:0] wr_data,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic signed [pse_pkg::DATA_W-1:0]  rd_data
);

  logic signed [pse_pkg::DATA_W-1:0] mem [MAX_SAMPLES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/pse_checker.sv
// Port-level checker for the sample percentile engine, bound to the top level.
// Depends on pse_pkg and the assertion macros header.
`default_nettype none
`include "sample_percentile_engine_top_defines.svh"
module pse_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [pse_pkg::DATA_W-1:0]  percentile_value,
  input wire logic [pse_pkg::TOTAL_W-1:0]        sample_total
);

  // Busy in the cycle after an item is taken
  `PSE_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "no busy after item")
  // A pending result blocks new items
  `PSE_ASSERT(a_stall_while_result, out_valid |-> in_stall, "item taken during result")
  // An empty set gives zero
  `PSE_ASSERT(a_empty_zero, out_valid && sample_total == '0 |-> percentile_value == '0,
    "empty set not zero")
  // A stalled result holds
  `PSE_ASSERT(a_result_holds, out_valid && out_stall |=> out_valid && $stable(percentile_value),
    "stalled result changed")
  // No input taken while reset is high
  `PSE_ASSERT_ALWAYS(a_reset_stall, rst |-> in_stall, "input open in reset")

endmodule

bind sample_percentile_engine_top pse_checker u_pse_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .percentile_value(percentile_value),
  .sample_total    (sample_total)
);
`default_nettype wire

### bench/tb_sample_percentile_engine_top.sv
// Self-checking bench for sample_percentile_engine_top: random sample sets,
// percentile register sweeps and stall pressure. Depends on rtl/pse_pkg.sv and the engine RTL.
`timescale 1ns / 100ps
`default_nettype none

// Expected-result tracker: keeps its own sorted set and fraction register
class percentile_scoreboard;
  typedef struct {
    logic signed [31:0] value;
    logic [8:0]         total;
    logic               ovf;
  } pct_result_t;

  int                 sorted_set[$];
  bit                 ovf_seen;
  logic [16:0]        fraction;
  pct_result_t        awaited[$];
  int                 mismatches;
  int                 max_samples;

  function new(int depth);
    max_samples = depth;
    fraction    = pse_pkg::FRAC_RST;
    mismatches  = 0;
    ovf_seen    = 0;
  endfunction

  function void set_fraction(logic [16:0] f);
    fraction = f;
  endfunction

  // Work out the interpolated percentile of the current set
  function logic signed [31:0] interpolate();
    longint n, p, pos, top, top_gap, idx, frac_part, lo, diff;
    n = sorted_set.size();
    if (n == 0) return 0;
    p = (fraction > pse_pkg::FRAC_ONE) ? 65536 : fraction;
    pos = (n - 1) * p;
    top = (n - 1) * 65536;
    if (pos < 655) return sorted_set[0];
    top_gap = (top >= pos) ? top - pos : pos - top;
    if (top_gap < 655) return sorted_set[n - 1];
    idx = pos >> 16;
    frac_part = pos & 64'hFFFF;
    if (idx + 1 >= n) return sorted_set[n - 1];
    lo = sorted_set[idx];
    diff = longint'(sorted_set[idx + 1]) - lo;
    return 32'(lo + ((diff * frac_part) >>> 16));
  endfunction

  // Note an accepted input item
  function void note_sample(logic signed [31:0] v, logic present, logic last);
    int j;
    pct_result_t r;
    if (present) begin
      if (sorted_set.size() < max_samples) begin
        j = 0;
        while (j < sorted_set.size() && sorted_set[j] <= v) j++;
        sorted_set.insert(j, v);
      end else begin
        ovf_seen = 1;
      end
    end
    if (last) begin
      r.value = interpolate();
      r.total = 9'(sorted_set.size());
      r.ovf   = ovf_seen;
      awaited.push_back(r);
      sorted_set.delete();
      ovf_seen = 0;
    end
  endfunction

  // Compare one accepted result with the oldest expectation
  function void check_result(logic signed [31:0] v, logic [8:0] tot, logic ov);
    pct_result_t e;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result value=%0d total=%0d ovf=%0b", v, tot, ov);
      return;
    end
    e = awaited.pop_front();
    if (v !== e.value || tot !== e.total || ov !== e.ovf) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: expected value=%0d total=%0d ovf=%0b, got value=%0d total=%0d ovf=%0b",
                 e.value, e.total, e.ovf, v, tot, ov);
    end
  endfunction
endclass

module tb_sample_percentile_engine_top;

  localparam int DEPTH      = pse_pkg::MAX_SAMPLES_DEF;
  localparam int IDLE_LIMIT = 40000;
  localparam int ITEM_GOAL  = 1700;

  logic                              clk;
  logic                              rst;
  logic                              cfg_wr_en;
  logic [pse_pkg::FRAC_W-1:0]        cfg_wr_data;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [pse_pkg::DATA_W-1:0] sample_value;
  logic                              sample_present;
  logic                              last_item;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [pse_pkg::DATA_W-1:0] percentile_value;
  logic [pse_pkg::TOTAL_W-1:0]       sample_total;
  logic                              overflowed;

  percentile_scoreboard sb;
  int  items_sent;
  int  idle_cycles;
  bit  hold_request;
  bit  pressure_run;

  sample_percentile_engine_top #(.MAX_SAMPLES(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_value(sample_value), .sample_present(sample_present), .last_item(last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .percentile_value(percentile_value), .sample_total(sample_total),
    .overflowed(overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Track accepted items on both sides
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_sample(sample_value, sample_present, last_item);
    if (!rst && out_valid && !out_stall)
      sb.check_result(percentile_value, sample_total, overflowed);
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    int mode, left;
    out_stall = 1'b1;
    mode = 0;
    left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        mode = 3;
        left = 3000;
      end else if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(50, 400);
      end
      left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 4);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_item(logic signed [31:0] v, logic present, logic last);
    in_valid       <= 1'b1;
    sample_value   <= v;
    sample_present <= present;
    last_item      <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drop valid for a random gap, sometimes none
  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for all results, let the block settle, then write the register
  task automatic write_fraction(logic [16:0] f);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= f;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_fraction(f);
  endtask

  function automatic logic signed [31:0] pick_value(int flavour);
    case (flavour)
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 3) == 0 ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // Send one set of the given size, with occasional empty items mixed in
  task automatic send_set(int size, int flavour, bit ascending);
    logic signed [31:0] v;
    v = -32'sd1000;
    for (int k = 0; k < size; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item($urandom, 1'b0, 1'b0);
        sender_gap();
      end
      if (ascending) v = v + $urandom_range(0, 5000);
      send_item(ascending ? v : pick_value(flavour), 1'b1, k == size - 1);
      sender_gap();
    end
    if (size == 0) begin
      send_item($urandom, 1'b0, 1'b1);
      sender_gap();
    end
  endtask

  initial begin
    logic [16:0] fracs[$];
    int size, fl;
    sb = new(DEPTH);
    items_sent     = 0;
    idle_cycles    = 0;
    hold_request   = 0;
    pressure_run   = 0;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    sample_value   = '0;
    sample_present = 1'b0;
    last_item      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset fraction, empty set, single sample, extremes
    send_item(32'sh12345678, 1'b0, 1'b1);
    send_item(32'sh7FFFFFFF, 1'b1, 1'b1);
    send_item(32'sh80000000, 1'b1, 1'b0);
    send_item(32'sh7FFFFFFF, 1'b1, 1'b1);
    send_item(-32'sd5, 1'b1, 1'b0);
    send_item(32'sd9, 1'b1, 1'b0);
    send_item(32'sd3, 1'b1, 1'b0);
    send_item(32'sd0, 1'b0, 1'b1);
    // Lowest percentile, then one, then above one
    write_fraction(17'd0);
    send_item(32'sd4, 1'b1, 1'b0);
    send_item(-32'sd4, 1'b1, 1'b1);
    write_fraction(pse_pkg::FRAC_ONE);
    send_item(32'sd4, 1'b1, 1'b0);
    send_item(-32'sd4, 1'b1, 1'b1);
    write_fraction(17'h1FFFF);
    send_item(32'sh80000000, 1'b1, 1'b0);
    send_item(32'sh7FFFFFFF, 1'b1, 1'b1);
    // Store full: ascending keeps the insertion short
    write_fraction(17'd40000);
    send_set(DEPTH + 4, 0, 1'b1);

    // Random phases over a sweep of fractions
    fracs = '{17'd1, 17'd654, 17'd655, 17'd65535, 17'd32768, 17'd65537, 17'd16384};
    while (items_sent < ITEM_GOAL) begin
      if (fracs.size() != 0) write_fraction(fracs.pop_front());
      else write_fraction($urandom_range(0, 131071));
      repeat (10) begin
        if (!pressure_run && items_sent > 300) begin
          pressure_run = 1;
          hold_request = 1;
        end
        fl = $urandom_range(0, 4);
        size = ($urandom_range(0, 39) == 0) ? $urandom_range(13, DEPTH) : $urandom_range(0, 12);
        send_set(size, fl, $urandom_range(0, 3) == 0);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

`default_nettype wire

### files.f
+incdir+rtl
rtl/pse_pkg.sv
rtl/pse_store.sv
rtl/sample_percentile_engine_top.sv
rtl/pse_checker.sv
bench/tb_sample_percentile_engine_top.sv
